>>> rtl/ptq_pkg.sv
package ptq_pkg;

	localparam int TAG_W  = 16;
	localparam int TIME_W = 8;
	localparam int PRI_W  = 4;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic ST_DONE    = 1'b0;
	localparam logic ST_REFUSED = 1'b1;

	localparam logic MODE_STACK = 1'b0;
	localparam logic MODE_QUEUE = 1'b1;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [TIME_W-1:0] run_time;
		logic [PRI_W-1:0]  pri;
	} ptq_entry_t;

	typedef struct packed {
		logic push;
		logic refuse;
		logic start;
		logic scan;
		logic remove;
		logic load_pop;
	} ptq_cmd_t;

	typedef struct packed {
		logic empty;
		logic out_ready;
		logic last;
	} ptq_sts_t;

endpackage

>>> rtl/ptq_ctrl.sv
module ptq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              opcode,
	input  ptq_pkg::ptq_sts_t sts,
	output ptq_pkg::ptq_cmd_t cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_REMOVE = 2'd2;
	localparam logic [1:0] S_DONE   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_stall = !sts.out_ready;
				if (in_valid && sts.out_ready) begin
					if (opcode == ptq_pkg::OP_PUSH) begin
						cmd.push = 1'b1;
					end else if (sts.empty) begin
						cmd.refuse = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.last) begin
					state_d = S_REMOVE;
				end
			end
			S_REMOVE: begin
				cmd.remove = 1'b1;
				if (sts.last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_ready) begin
					cmd.load_pop = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/ptq_dp.sv
module ptq_dp #(
	parameter int CAPACITY = 16,
	parameter int LEVELS   = 10,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_wdata,
	input  logic [ptq_pkg::TAG_W-1:0]  task_tag,
	input  logic [ptq_pkg::TIME_W-1:0] task_time,
	input  logic [ptq_pkg::PRI_W-1:0]  task_priority,
	input  ptq_pkg::ptq_cmd_t          cmd,
	output ptq_pkg::ptq_sts_t          sts,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       status,
	output logic [ptq_pkg::TAG_W-1:0]  out_tag,
	output logic [ptq_pkg::TIME_W-1:0] out_time,
	output logic [ptq_pkg::PRI_W-1:0]  out_priority,
	output logic [CNT_W-1:0]           occupancy
);

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

	ptq_pkg::ptq_entry_t slot_q [CAPACITY];
	ptq_pkg::ptq_entry_t best_q;
	ptq_pkg::ptq_entry_t new_entry;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] step_q;
	logic [CNT_W-1:0] best_idx_q;
	logic             found_q;
	logic             dropped_q;
	logic             order_mode_q;

	logic             out_valid_q;
	logic             status_q;
	logic [ptq_pkg::TAG_W-1:0]  out_tag_q;
	logic [ptq_pkg::TIME_W-1:0] out_time_q;
	logic [ptq_pkg::PRI_W-1:0]  out_pri_q;
	logic [CNT_W-1:0]           occ_q;

	logic pri_ok;
	logic push_ok;
	logic at_best;
	logic drop;
	logic shift;
	logic take;

	assign new_entry = '{tag: task_tag, run_time: task_time, pri: task_priority};

	assign pri_ok  = (task_priority != '0) && (task_priority <= ptq_pkg::PRI_W'(LEVELS));
	assign push_ok = cmd.push && pri_ok && (count_q != CAP_CNT);
	assign at_best = (step_q == best_idx_q);
	assign drop    = cmd.remove && at_best;
	assign shift   = cmd.scan || cmd.remove;

	assign take = !found_q || (slot_q[0].pri < best_q.pri)
		|| ((order_mode_q == ptq_pkg::MODE_STACK) && (slot_q[0].pri == best_q.pri));

	assign sts.empty     = (count_q == '0);
	assign sts.out_ready = !out_valid_q || !out_stall;
	assign sts.last      = dropped_q ? (step_q == count_q) : (step_q == count_q - ONE_CNT);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
		localparam logic [CNT_W-1:0] I0 = CNT_W'(i);
		localparam logic [CNT_W-1:0] I1 = CNT_W'(i + 1);
		if (i < CAPACITY - 1) begin : g_mid
			always_ff @(posedge clk) begin
				if (push_ok && (count_q == I0)) begin
					slot_q[i] <= new_entry;
				end else if (shift) begin
					if (I1 < count_q) begin
						slot_q[i] <= slot_q[i+1];
					end else if ((I1 == count_q) && !drop) begin
						slot_q[i] <= slot_q[0];
					end
				end
			end
		end else begin : g_end
			always_ff @(posedge clk) begin
				if (push_ok && (count_q == I0)) begin
					slot_q[i] <= new_entry;
				end else if (shift && (I1 == count_q) && !drop) begin
					slot_q[i] <= slot_q[0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			step_q       <= '0;
			best_idx_q   <= '0;
			found_q      <= 1'b0;
			dropped_q    <= 1'b0;
			order_mode_q <= ptq_pkg::MODE_STACK;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				order_mode_q <= cfg_wdata;
			end
			if (push_ok) begin
				count_q <= count_q + ONE_CNT;
			end else if (drop) begin
				count_q <= count_q - ONE_CNT;
			end
			if (cmd.start) begin
				step_q    <= '0;
				found_q   <= 1'b0;
				dropped_q <= 1'b0;
			end else if (cmd.scan) begin
				step_q <= sts.last ? '0 : step_q + ONE_CNT;
				if (take) begin
					found_q    <= 1'b1;
					best_idx_q <= step_q;
				end
			end else if (cmd.remove) begin
				step_q <= step_q + ONE_CNT;
				if (drop) begin
					dropped_q <= 1'b1;
				end
			end
			if (cmd.push || cmd.refuse || cmd.load_pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan && take) begin
			best_q <= slot_q[0];
		end
		if (cmd.push) begin
			status_q   <= push_ok ? ptq_pkg::ST_DONE : ptq_pkg::ST_REFUSED;
			out_tag_q  <= '0;
			out_time_q <= '0;
			out_pri_q  <= '0;
			occ_q      <= push_ok ? count_q + ONE_CNT : count_q;
		end else if (cmd.refuse) begin
			status_q   <= ptq_pkg::ST_REFUSED;
			out_tag_q  <= '0;
			out_time_q <= '0;
			out_pri_q  <= '0;
			occ_q      <= count_q;
		end else if (cmd.load_pop) begin
			status_q   <= ptq_pkg::ST_DONE;
			out_tag_q  <= best_q.tag;
			out_time_q <= best_q.run_time;
			out_pri_q  <= best_q.pri;
			occ_q      <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_tag      = out_tag_q;
	assign out_time     = out_time_q;
	assign out_priority = out_pri_q;
	assign occupancy    = occ_q;

endmodule

>>> rtl/priority_task_queue_core.sv
// Bounded priority task store. Each request is a push (tag, run time, priority
// 1..LEVELS) or a pop of the waiting task with the lowest priority number; ties
// go newest first when order_mode is 0 and oldest first when it is 1. Every
// request returns one result with a status (1 = refused: store full, priority
// out of range, or pop from an empty store) and the number of tasks left. A push
// or a refused pop is answered at the accept edge and the next request can be
// taken in the following cycle. A pop keeps the block busy after its accept:
// the tasks sit in a ring of slot registers that rotates one slot per cycle,
// once to find the winner and once more to close the gap it leaves. The output
// register lets a new request in while the previous result is still held, as
// long as that result is not stalled.
module priority_task_queue_core #(
	parameter int CAPACITY = 16,
	parameter int LEVELS   = 10,
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [ptq_pkg::TAG_W-1:0]  task_tag,
	input  logic [ptq_pkg::TIME_W-1:0] task_time,
	input  logic [ptq_pkg::PRI_W-1:0]  task_priority,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       status,
	output logic [ptq_pkg::TAG_W-1:0]  out_tag,
	output logic [ptq_pkg::TIME_W-1:0] out_time,
	output logic [ptq_pkg::PRI_W-1:0]  out_priority,
	output logic [CNT_W-1:0]           occupancy
);

	ptq_pkg::ptq_cmd_t cmd;
	ptq_pkg::ptq_sts_t sts;

	ptq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptq_dp #(
		.CAPACITY (CAPACITY),
		.LEVELS   (LEVELS),
		.CNT_W    (CNT_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.task_tag      (task_tag),
		.task_time     (task_time),
		.task_priority (task_priority),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.out_tag       (out_tag),
		.out_time      (out_time),
		.out_priority  (out_priority),
		.occupancy     (occupancy)
	);

endmodule

>>> rtl/ptq_chk.sv
module ptq_chk #(
	parameter int CAPACITY = 16,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       status,
	input logic [ptq_pkg::TAG_W-1:0]  out_tag,
	input logic [ptq_pkg::TIME_W-1:0] out_time,
	input logic [ptq_pkg::PRI_W-1:0]  out_priority,
	input logic [CNT_W-1:0]           occupancy
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_tag) && $stable(occupancy))
		else $error("stalled result changed");

	a_no_accept_over_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> !(out_valid && out_stall))
		else $error("request taken while result stalled");

	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ptq_pkg::ST_REFUSED) |->
			(out_tag == '0) && (out_time == '0) && (out_priority == '0))
		else $error("refused result carries task fields");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occupancy <= CNT_W'(CAPACITY)))
		else $error("occupancy above capacity");

endmodule

bind priority_task_queue_core ptq_chk #(
	.CAPACITY (CAPACITY),
	.CNT_W    (CNT_W)
) u_ptq_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.out_tag      (out_tag),
	.out_time     (out_time),
	.out_priority (out_priority),
	.occupancy    (occupancy)
);

>>> sim/tb_priority_task_queue_core.sv
`timescale 1ns / 1ps

module tb_priority_task_queue_core;

	localparam int CAPACITY    = 16;
	localparam int LEVELS      = 10;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 300;
	localparam int SEG_ITEMS   = 172;

	typedef struct packed {
		logic                       op;
		logic [ptq_pkg::TAG_W-1:0]  tag;
		logic [ptq_pkg::TIME_W-1:0] tim;
		logic [ptq_pkg::PRI_W-1:0]  pri;
	} task_req_t;

	typedef struct packed {
		logic                       status;
		logic [ptq_pkg::TAG_W-1:0]  tag;
		logic [ptq_pkg::TIME_W-1:0] tim;
		logic [ptq_pkg::PRI_W-1:0]  pri;
		logic [CNT_W-1:0]           occ;
	} task_res_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic                         cfg_wdata = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic                         opcode = ptq_pkg::OP_PUSH;
	logic [ptq_pkg::TAG_W-1:0]    task_tag = '0;
	logic [ptq_pkg::TIME_W-1:0]   task_time = '0;
	logic [ptq_pkg::PRI_W-1:0]    task_priority = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic                         status;
	logic [ptq_pkg::TAG_W-1:0]    out_tag;
	logic [ptq_pkg::TIME_W-1:0]   out_time;
	logic [ptq_pkg::PRI_W-1:0]    out_priority;
	logic [CNT_W-1:0]             occupancy;

	task_req_t pending_reqs[$];
	task_res_t expected_results[$];
	task_req_t offered_req;

	ptq_pkg::ptq_entry_t model_slots[CAPACITY];
	int                  model_count = 0;
	logic                model_mode = ptq_pkg::MODE_STACK;

	int gen_count = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int long_hold_req = 0;
	int long_hold_seen = 0;
	int hold_left = 0;
	int errors = 0;
	int cycles = 0;

	priority_task_queue_core #(
		.CAPACITY(CAPACITY),
		.LEVELS(LEVELS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.task_tag(task_tag),
		.task_time(task_time),
		.task_priority(task_priority),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.out_tag(out_tag),
		.out_time(out_time),
		.out_priority(out_priority),
		.occupancy(occupancy)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic task_res_t predict_result(input task_req_t r);
		task_res_t e;
		int best;
		int best_pri;
		e = '0;
		e.status = ptq_pkg::ST_REFUSED;
		if (r.op == ptq_pkg::OP_PUSH) begin
			if (model_count < CAPACITY && r.pri >= 1 && r.pri <= LEVELS) begin
				model_slots[model_count] = '{tag: r.tag, run_time: r.tim, pri: r.pri};
				model_count++;
				e.status = ptq_pkg::ST_DONE;
			end
		end else if (model_count > 0) begin
			best = 0;
			best_pri = 16;
			for (int i = 0; i < model_count; i++) begin
				if (int'(model_slots[i].pri) < best_pri ||
				    (model_mode == ptq_pkg::MODE_STACK &&
				     int'(model_slots[i].pri) == best_pri)) begin
					best_pri = int'(model_slots[i].pri);
					best = i;
				end
			end
			e.tag = model_slots[best].tag;
			e.tim = model_slots[best].run_time;
			e.pri = model_slots[best].pri;
			for (int i = best; i + 1 < model_count; i++)
				model_slots[i] = model_slots[i + 1];
			model_count--;
			e.status = ptq_pkg::ST_DONE;
		end
		e.occ = model_count[CNT_W-1:0];
		return e;
	endfunction

	// request driver
	always @(posedge clk) begin
		task_req_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_results.push_back(predict_result(offered_req));
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
					nxt = pending_reqs.pop_front();
					offered_req = nxt;
					in_valid <= 1'b1;
					opcode <= nxt.op;
					task_tag <= nxt.tag;
					task_time <= nxt.tim;
					task_priority <= nxt.pri;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		task_res_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result with no pending request: status %0d occupancy %0d",
					       status, occupancy);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (status !== e.status) begin
						$error("status expected %0d actual %0d", e.status, status);
						errors++;
					end
					if (out_tag !== e.tag) begin
						$error("out_tag expected %0h actual %0h", e.tag, out_tag);
						errors++;
					end
					if (out_time !== e.tim) begin
						$error("out_time expected %0d actual %0d", e.tim, out_time);
						errors++;
					end
					if (out_priority !== e.pri) begin
						$error("out_priority expected %0d actual %0d", e.pri, out_priority);
						errors++;
					end
					if (occupancy !== e.occ) begin
						$error("occupancy expected %0d actual %0d", e.occ, occupancy);
						errors++;
					end
				end
			end
			if (long_hold_seen != long_hold_req) begin
				long_hold_seen = long_hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rcv_idle_pct);
			end
		end
	end

	task automatic add_req(input logic op, input logic [ptq_pkg::TAG_W-1:0] tag,
	                       input logic [ptq_pkg::TIME_W-1:0] tim,
	                       input logic [ptq_pkg::PRI_W-1:0] pri);
		pending_reqs.push_back('{op: op, tag: tag, tim: tim, pri: pri});
		if (op == ptq_pkg::OP_PUSH) begin
			if (gen_count < CAPACITY && pri >= 1 && pri <= LEVELS)
				gen_count++;
		end else if (gen_count > 0) begin
			gen_count--;
		end
	endtask

	task automatic drain_and_configure(input logic mode);
		do @(posedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		model_mode = mode;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_random_reqs(input int n);
		logic fill;
		logic op;
		logic [ptq_pkg::PRI_W-1:0] pri;
		fill = 1'b1;
		for (int i = 0; i < n; i++) begin
			if (i % 32 == 0)
				fill = 1'($urandom_range(1));
			if (gen_count >= CAPACITY)
				op = ($urandom_range(99) < 85) ? ptq_pkg::OP_POP : ptq_pkg::OP_PUSH;
			else if (gen_count == 0)
				op = ($urandom_range(99) < 85) ? ptq_pkg::OP_PUSH : ptq_pkg::OP_POP;
			else
				op = ($urandom_range(99) < (fill ? 75 : 25)) ?
				     ptq_pkg::OP_PUSH : ptq_pkg::OP_POP;
			case ($urandom_range(9))
				0: pri = ($urandom_range(1)) ? 4'd0 :
				         ptq_pkg::PRI_W'($urandom_range(15, LEVELS + 1));
				1, 2, 3, 4: pri = ptq_pkg::PRI_W'($urandom_range(3, 1));
				default: pri = ptq_pkg::PRI_W'($urandom_range(LEVELS, 1));
			endcase
			add_req(op, ptq_pkg::TAG_W'($urandom), ptq_pkg::TIME_W'($urandom), pri);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= ptq_pkg::MODE_STACK;
		model_mode = ptq_pkg::MODE_STACK;
		@(posedge clk);
		cfg_we <= 1'b0;
		snd_idle_pct = 26;
		rcv_idle_pct = 48;

		add_req(ptq_pkg::OP_POP, 16'h1234, 8'h56, 4'd3);
		add_req(ptq_pkg::OP_PUSH, 16'h0001, 8'd1, 4'd0);
		add_req(ptq_pkg::OP_PUSH, 16'h0002, 8'd2, 4'd15);
		add_req(ptq_pkg::OP_PUSH, 16'h0003, 8'd3, 4'd11);
		add_req(ptq_pkg::OP_PUSH, 16'hffff, 8'hff, 4'd10);
		add_req(ptq_pkg::OP_PUSH, 16'h0000, 8'h00, 4'd1);
		add_req(ptq_pkg::OP_PUSH, 16'h00a0, 8'd10, 4'd5);
		add_req(ptq_pkg::OP_PUSH, 16'h00b0, 8'd11, 4'd5);
		add_req(ptq_pkg::OP_PUSH, 16'h00c0, 8'd12, 4'd5);
		add_req(ptq_pkg::OP_POP, 16'h0000, 8'h00, 4'd0);
		add_req(ptq_pkg::OP_POP, 16'hffff, 8'hff, 4'd15);
		while (gen_count < CAPACITY)
			add_req(ptq_pkg::OP_PUSH, ptq_pkg::TAG_W'($urandom),
			        ptq_pkg::TIME_W'($urandom),
			        ptq_pkg::PRI_W'($urandom_range(LEVELS, 1)));
		add_req(ptq_pkg::OP_PUSH, 16'h5a5a, 8'h5a, 4'd1);

		for (int seg = 0; seg < 6; seg++) begin
			drain_and_configure((seg % 2 == 0) ? ptq_pkg::MODE_QUEUE : ptq_pkg::MODE_STACK);
			case (seg / 2)
				0: begin
					snd_idle_pct = 26;
					rcv_idle_pct = 48;
				end
				1: begin
					snd_idle_pct = 48;
					rcv_idle_pct = 26;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			add_random_reqs(SEG_ITEMS);
			if (seg == 1)
				long_hold_req++;
		end

		do @(posedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
